// ----- hdl/ray_box_nearest_pick_macros.svh -----
// Assertion helpers for ray_box_nearest_pick; clk and rst come from the module scope.
`ifndef RAY_BOX_NEAREST_PICK_MACROS_SVH
`define RAY_BOX_NEAREST_PICK_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RBNP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RBNP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rbnp_pkg.sv -----
`default_nettype none
package rbnp_pkg;

  localparam int POS_W        = 25;
  localparam int DIR_W        = 16;
  localparam int DIST_W       = 22;
  localparam int IDX_W        = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int EXT_W        = POS_W + 1;
  localparam int DIFF_W       = EXT_W + 1;
  localparam int MAG_W        = DIFF_W - 1;
  localparam int FRAC_SHIFT   = DIR_W - 1;
  localparam int QMAG_W       = MAG_W + FRAC_SHIFT;
  localparam int T_W          = QMAG_W + 1;
  localparam int DIV_RADIX    = 4;
  localparam int DIV_STEPS    = (QMAG_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_N_W      = DIV_STEPS * DIV_RADIX;
  localparam int ENTITY_COUNT = 1024;
  localparam int ENT_CMP_W    = 13;
  localparam int HALF_CUBE    = 2048;
  localparam int RANGE_LIMIT  = 2097152;
  localparam int DIR_RESET    = 32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ORIGIN_Z     = 3'd2,
    REG_DIR_X        = 3'd3,
    REG_DIR_Y        = 3'd4,
    REG_DIR_Z        = 3'd5,
    REG_MAX_DISTANCE = 3'd6,
    REG_SKIPPED      = 3'd7
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- hdl/rbnp_div.sv -----
`default_nettype none
module rbnp_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rbnp_pkg::MAG_W-1:0]  dividend,
  input  wire logic [rbnp_pkg::DIR_W-1:0]  divisor,
  output logic                             done,
  output logic [rbnp_pkg::QMAG_W-1:0]      quotient
);
  import rbnp_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                 active;
  logic [CNT_W-1:0]     count;
  logic [DIV_N_W-1:0]   numer;
  logic [DIV_N_W-1:0]   quot;
  logic [DIR_W-1:0]     rem;
  logic [DIR_W-1:0]     dvsr;
  logic [DIR_W-1:0]     rem_next;
  logic [DIV_RADIX-1:0] qbits;

  always_comb begin
    logic [DIR_W:0] trial;
    rem_next = rem;
    qbits    = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_next, numer[DIV_N_W-1-i]};
      if (trial >= {1'b0, dvsr}) begin
        trial = trial - {1'b0, dvsr};
        qbits[DIV_RADIX-1-i] = 1'b1;
      end
      rem_next = trial[DIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= '0;
        numer  <= DIV_N_W'({dividend, {FRAC_SHIFT{1'b0}}});
        rem    <= '0;
        dvsr   <= divisor;
      end else if (active) begin
        numer <= numer << DIV_RADIX;
        quot  <= {quot[DIV_N_W-DIV_RADIX-1:0], qbits};
        rem   <= rem_next;
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = quot[QMAG_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/ray_box_nearest_pick.sv -----
// Nearest-hit picker: candidate boxes stream in one item at a time and are
// slab-tested against the configured ray; the item flagged last_entity yields
// one result (found flag, index, entry distance) and opens a new pick. A box
// with all three direction components nonzero needs six slab distances from
// the shared divider, which retires 4 quotient bits per cycle over 11 steps.
// An axis with a zero direction skips the divider and only checks the origin
// against its slab; a skipped index goes straight to the finish state.
// in_ready is high only between items; a finished result waits in the output
// register while the next item is taken.
`default_nettype none
module ray_box_nearest_pick (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [rbnp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rbnp_pkg::POS_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rbnp_pkg::IDX_W-1:0]          entity_index,
  input  wire logic                                linked,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   box_min_x,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   box_min_y,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   box_min_z,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   box_max_x,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   box_max_y,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   box_max_z,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   center_x,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   center_y,
  input  wire logic signed [rbnp_pkg::POS_W-1:0]   center_z,
  input  wire logic                                last_entity,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     hit_found,
  output logic [rbnp_pkg::IDX_W-1:0]               hit_index,
  output logic [rbnp_pkg::DIST_W-1:0]              hit_distance
);
  import rbnp_pkg::*;
  `include "ray_box_nearest_pick_macros.svh"

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_DIV    = 6'b000100,
    S_AXIS   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic signed [POS_W-1:0]  origin [3];
  logic signed [DIR_W-1:0]  dir [3];
  logic [DIST_W-1:0]        max_distance;
  logic [IDX_W-1:0]         skipped_entity;

  logic [DIST_W-1:0]        nearest_distance;
  logic [IDX_W-1:0]         best_index;
  logic                     any_hit;
  logic                     pick_open;

  logic [IDX_W-1:0]         idx_r;
  logic                     last_r;
  logic signed [EXT_W-1:0]  low_r [3];
  logic signed [EXT_W-1:0]  high_r [3];
  logic [1:0]               axis;
  logic                     bsel;
  logic                     neg_r;
  logic                     miss;
  logic signed [T_W-1:0]    ta;
  logic signed [T_W-1:0]    first;
  logic signed [T_W-1:0]    exitd;

  logic signed [EXT_W-1:0]  low_in [3];
  logic signed [EXT_W-1:0]  high_in [3];
  logic [DIST_W-1:0]        load_limit;
  logic                     take;
  logic                     tested;
  logic signed [POS_W-1:0]  o_sel;
  logic signed [DIR_W-1:0]  d_sel;
  logic signed [EXT_W-1:0]  bound_sel;
  logic signed [EXT_W-1:0]  o_ext;
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         diff_mag;
  logic [DIR_W-1:0]         d_mag;
  logic                     div_start;
  logic                     div_done;
  logic [QMAG_W-1:0]        div_q;
  logic signed [T_W-1:0]    q_t;
  logic signed [T_W-1:0]    t_lo;
  logic signed [T_W-1:0]    t_hi;
  logic                     out_free;

  always_comb begin
    if (linked) begin
      low_in[0]  = EXT_W'(box_min_x);
      low_in[1]  = EXT_W'(box_min_y);
      low_in[2]  = EXT_W'(box_min_z);
      high_in[0] = EXT_W'(box_max_x);
      high_in[1] = EXT_W'(box_max_y);
      high_in[2] = EXT_W'(box_max_z);
    end else begin
      low_in[0]  = EXT_W'(center_x) - EXT_W'(HALF_CUBE);
      low_in[1]  = EXT_W'(center_y) - EXT_W'(HALF_CUBE);
      low_in[2]  = EXT_W'(center_z) - EXT_W'(HALF_CUBE);
      high_in[0] = EXT_W'(center_x) + EXT_W'(HALF_CUBE);
      high_in[1] = EXT_W'(center_y) + EXT_W'(HALF_CUBE);
      high_in[2] = EXT_W'(center_z) + EXT_W'(HALF_CUBE);
    end
  end

  assign load_limit = (max_distance > DIST_W'(RANGE_LIMIT)) ? DIST_W'(RANGE_LIMIT)
                                                            : max_distance;
  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign tested   = (entity_index != skipped_entity) &&
                    (ENT_CMP_W'(entity_index) < ENT_CMP_W'(ENTITY_COUNT));
  assign out_free = !out_valid || out_ready;

  assign o_sel     = origin[axis];
  assign d_sel     = dir[axis];
  assign bound_sel = bsel ? high_r[axis] : low_r[axis];
  assign o_ext     = EXT_W'(o_sel);
  assign diff      = DIFF_W'(bound_sel) - DIFF_W'(o_sel);
  assign diff_mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign d_mag     = d_sel[DIR_W-1] ? DIR_W'(-d_sel) : DIR_W'(d_sel);
  assign div_start = (state == S_SETUP) && (d_sel != '0);
  assign q_t       = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign t_lo      = (ta < q_t) ? ta : q_t;
  assign t_hi      = (ta < q_t) ? q_t : ta;

  rbnp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (d_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = tested ? S_SETUP : S_FINISH;
        end
      end
      S_SETUP: begin
        if (d_sel != '0) begin
          state_next = S_DIV;
        end else if (axis == 2'd2) begin
          state_next = S_DECIDE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = bsel ? S_AXIS : S_SETUP;
        end
      end
      S_AXIS: begin
        state_next = (axis == 2'd2) ? S_DECIDE : S_SETUP;
      end
      S_DECIDE: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!last_r || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]      <= '0;
      origin[1]      <= '0;
      origin[2]      <= '0;
      dir[0]         <= DIR_W'(DIR_RESET);
      dir[1]         <= '0;
      dir[2]         <= '0;
      max_distance   <= DIST_W'(RANGE_LIMIT);
      skipped_entity <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:     origin[0]      <= cfg_data;
        REG_ORIGIN_Y:     origin[1]      <= cfg_data;
        REG_ORIGIN_Z:     origin[2]      <= cfg_data;
        REG_DIR_X:        dir[0]         <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:        dir[1]         <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:        dir[2]         <= cfg_data[DIR_W-1:0];
        REG_MAX_DISTANCE: max_distance   <= cfg_data[DIST_W-1:0];
        REG_SKIPPED:      skipped_entity <= cfg_data[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pick_open        <= 1'b0;
      any_hit          <= 1'b0;
      best_index       <= '0;
      nearest_distance <= DIST_W'(RANGE_LIMIT);
      out_valid        <= 1'b0;
      axis             <= '0;
      bsel             <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_FINISH) && last_r && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            idx_r <= entity_index;
            last_r <= last_entity;
            for (int a = 0; a < 3; a++) begin
              low_r[a]  <= low_in[a];
              high_r[a] <= high_in[a];
            end
            axis  <= '0;
            bsel  <= 1'b0;
            miss  <= 1'b0;
            first <= '0;
            pick_open <= 1'b1;
            if (!pick_open) begin
              nearest_distance <= load_limit;
              best_index       <= '0;
              any_hit          <= 1'b0;
              exitd            <= $signed(T_W'(load_limit));
            end else begin
              exitd <= $signed(T_W'(nearest_distance));
            end
          end
        end
        S_SETUP: begin
          if (d_sel != '0) begin
            neg_r <= diff[DIFF_W-1] ^ d_sel[DIR_W-1];
          end else begin
            if ((o_ext < low_r[axis]) || (o_ext > high_r[axis])) begin
              miss <= 1'b1;
            end
            axis <= axis + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!bsel) begin
              ta   <= q_t;
              bsel <= 1'b1;
            end else begin
              bsel <= 1'b0;
              if (t_lo > first) begin
                first <= t_lo;
              end
              if (t_hi < exitd) begin
                exitd <= t_hi;
              end
            end
          end
        end
        S_AXIS: begin
          axis <= axis + 1'b1;
        end
        S_DECIDE: begin
          if (!miss && (first <= exitd)) begin
            nearest_distance <= first[DIST_W-1:0];
            best_index       <= idx_r;
            any_hit          <= 1'b1;
          end
        end
        S_FINISH: begin
          if (last_r && out_free) begin
            hit_found        <= any_hit;
            hit_index        <= any_hit ? best_index : '0;
            hit_distance     <= any_hit ? nearest_distance : '0;
            pick_open        <= 1'b0;
            any_hit          <= 1'b0;
            best_index       <= '0;
            nearest_distance <= load_limit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `RBNP_ASSERT_NXT(a_busy_after_accept, take, !in_ready, "ready high right after an item")
  `RBNP_ASSERT_IMP(a_idle_no_div, in_ready, !div_done, "divider finished while idle")
  `RBNP_ASSERT_IMP(a_empty_result, out_valid && !hit_found,
                   hit_index == '0 && hit_distance == '0, "miss result not cleared")
  `RBNP_ASSERT_IMP(a_nearest_range, pick_open, nearest_distance <= DIST_W'(RANGE_LIMIT),
                   "nearest distance beyond range limit")

endmodule
`default_nettype wire
